@@ sv/krp_pkg.sv @@
// Shared types and constants for the key response packet parser.
`default_nettype none
package krp_pkg;

  // Packet geometry
  localparam int PACKET_BYTES = 6;
  localparam int UP_TAPS      = PACKET_BYTES - 1;
  localparam int LAST_INDEX   = 5;
  localparam int KEY_SHIFT    = 5;

  // Byte constants
  localparam logic [7:0] START_CHAR = 8'h6B;
  localparam logic [7:0] PORT_BITS  = 8'h0F;
  localparam logic [7:0] KEY_BITS   = 8'hE0;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // Held-count limits
  localparam logic signed [7:0] HELD_MAX = 8'sh7F;
  localparam logic signed [7:0] HELD_MIN = -8'sd128;

  // Configuration register indexes
  localparam logic [1:0] CFG_RESERVED_MASK = 2'd0;
  localparam logic [1:0] CFG_RELEASE_MASK  = 2'd1;
  localparam logic [1:0] CFG_LENIENT_LAST  = 2'd2;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_t;

  // Controls common to every buffer cell
  typedef struct packed {
    logic       wr;    // byte beat accepted
    logic       drop;  // shift left by pos
    logic [2:0] pos;   // shift distance, 1 to 5
    logic       clr;   // empty the buffer
  } cell_ctrl_t;

endpackage : krp_pkg
`default_nettype wire

@@ sv/krp_cell.sv @@
// One byte cell of the packet buffer: capture, resync shift and start compare.
`default_nettype none
module krp_cell (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire krp_pkg::cell_ctrl_t                    ctrl,
  input  wire logic                                   here,
  input  wire logic [7:0]                             rx_byte,
  input  wire logic [krp_pkg::UP_TAPS-1:0][7:0]       up,
  output logic      [7:0]                             w,
  output logic                                        is_k
);
  import krp_pkg::*;

  logic [7:0] q_r;
  logic [7:0] q_nxt;
  logic [7:0] shifted;

  // Value after this beat's byte is written
  assign w    = here ? rx_byte : q_r;
  assign is_k = (w == START_CHAR);

  // Pick the byte pos places upstream
  always_comb begin
    shifted = NUL_BYTE;
    for (int j = 0; j < UP_TAPS; j++) begin
      if (ctrl.pos == 3'(j + 1)) shifted = up[j];
    end
  end

  always_comb begin
    if (ctrl.clr) begin
      q_nxt = NUL_BYTE;
    end else if (ctrl.drop) begin
      q_nxt = shifted;
    end else begin
      q_nxt = w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= NUL_BYTE;
    end else if (ctrl.wr) begin
      q_r <= q_nxt;
    end
  end

endmodule : krp_cell
`default_nettype wire

@@ sv/krp_count.sv @@
// Saturating signed count of keys held.
`default_nettype none
module krp_count (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        clr,
  input  wire logic        inc,
  input  wire logic        dec,
  output logic signed [7:0] held
);
  import krp_pkg::*;

  logic signed [7:0] held_r;
  logic signed [7:0] held_nxt;

  always_comb begin
    held_nxt = held_r;
    if (clr) begin
      held_nxt = 8'sd0;
    end else if (inc && (held_r != HELD_MAX)) begin
      held_nxt = held_r + 8'sd1;
    end else if (dec && (held_r != HELD_MIN)) begin
      held_nxt = held_r - 8'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 8'sd0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign held = held_r;

endmodule : krp_count
`default_nettype wire

@@ sv/key_response_packet_resync_parser.sv @@
// Key response packet parser: top level with cell row, decode and result register.
//
// Input channel (in_valid/in_ready): one beat carries an opcode and a byte.
// Opcode 0 pushes in_rx_byte into the six-byte packet buffer; opcode 1
// zeroes the held-key count. Every input beat gives exactly one result beat.
// Result channel (out_valid/out_ready): event, port, key, response time and
// the held-key count after that beat.
// The result is registered and appears the cycle after its input beat.
// Throughput is one beat per cycle while out_ready is high; the buffer update,
// start compare and resync shift all settle in the byte cell row in that cycle.
// A single result register sits between the channels. in_ready is high
// whenever that register is empty or being drained, so a stalled receiver
// holds the result steady and back-pressures the input after one beat.
// Synchronous reset empties the buffer, zeroes the count, drops any pending
// result and loads the configuration defaults (reserved mask 0, release
// mask 0x10, strict last byte). Configuration writes apply to later beats.
`default_nettype none
module key_response_packet_resync_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_res,
  output logic [3:0]       out_port,
  output logic [2:0]       out_key,
  output logic [31:0]      out_resp_time,
  output logic signed [7:0] out_keys_held
);
  import krp_pkg::*;

  // Configuration registers
  logic [7:0] reserved_mask_r;
  logic [7:0] release_mask_r;
  logic       lenient_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_mask_r <= 8'h00;
      release_mask_r  <= 8'h10;
      lenient_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESERVED_MASK: reserved_mask_r <= cfg_wdata;
        CFG_RELEASE_MASK:  release_mask_r  <= cfg_wdata;
        CFG_LENIENT_LAST:  lenient_r       <= cfg_wdata[0];
        default:           ;
      endcase
    end
  end

  // Handshake
  logic accept;
  logic step;
  logic out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign step     = accept && !in_opcode;

  // Fill count, 0 to 5 between beats
  logic [2:0] fill_r;
  logic [2:0] fill_nxt;
  logic [2:0] nf;

  assign nf = fill_r + 3'd1;

  // Cell row
  cell_ctrl_t                                ctrl;
  logic [PACKET_BYTES-1:0][7:0]              w_p;
  logic [PACKET_BYTES-1:0]                   k_p;
  logic [PACKET_BYTES+UP_TAPS-1:0][7:0]      w_ext;

  assign w_ext = {(UP_TAPS * 8)'(0), w_p};

  for (genvar i = 0; i < PACKET_BYTES; i++) begin : g_cell
    krp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .here    (fill_r == 3'(i)),
      .rx_byte (in_rx_byte),
      .up      (w_ext[i+UP_TAPS:i+1]),
      .w       (w_p[i]),
      .is_k    (k_p[i])
    );
  end

  // Packet decode on the written buffer
  logic valid_start;
  logic full;
  logic last_ok;
  logic ev_hit;
  logic keep_start;
  logic found;
  logic [2:0] pos;
  logic pressed;

  assign valid_start = k_p[0] && ((w_p[1] & reserved_mask_r) == 8'h00);
  assign full        = (nf == 3'(PACKET_BYTES));
  assign last_ok     = lenient_r || (w_p[LAST_INDEX] == NUL_BYTE);
  assign ev_hit      = valid_start && full && last_ok;
  assign keep_start  = valid_start && !(full && !last_ok);
  assign pressed     = (w_p[1] & release_mask_r) == release_mask_r;

  // First later start byte, lowest position wins
  always_comb begin
    found = 1'b0;
    pos   = 3'd0;
    for (int i = PACKET_BYTES - 1; i >= 1; i--) begin
      if (k_p[i]) begin
        found = 1'b1;
        pos   = 3'(i);
      end
    end
  end

  always_comb begin
    ctrl.wr   = step;
    ctrl.drop = !keep_start && found;
    ctrl.pos  = pos;
    ctrl.clr  = full && !ctrl.drop;
  end

  always_comb begin
    if (ctrl.clr) begin
      fill_nxt = 3'd0;
    end else if (ctrl.drop) begin
      fill_nxt = nf - pos;
    end else begin
      fill_nxt = nf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
    end else if (step) begin
      fill_r <= fill_nxt;
    end
  end

  // Held-key count
  krp_count u_count (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (accept && in_opcode),
    .inc   (step && ev_hit && pressed),
    .dec   (step && ev_hit && !pressed),
    .held  (out_keys_held)
  );

  // Result register
  event_t      event_r;
  logic [3:0]  port_r;
  logic [2:0]  key_r;
  logic [31:0] rt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (step && ev_hit) begin
        event_r <= pressed ? EV_PRESS : EV_RELEASE;
        port_r  <= 4'(w_p[1] & PORT_BITS);
        key_r   <= 3'((w_p[1] & KEY_BITS) >> KEY_SHIFT);
        rt_r    <= {w_p[5], w_p[4], w_p[3], w_p[2]};
      end else begin
        event_r <= EV_NONE;
        port_r  <= 4'd0;
        key_r   <= 3'd0;
        rt_r    <= 32'd0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = event_r;
  assign out_port      = port_r;
  assign out_key       = key_r;
  assign out_resp_time = rt_r;

endmodule : key_response_packet_resync_parser
`default_nettype wire

@@ sv/krp_checker.sv @@
// Port-level checks for the key response packet parser, bound to the top level.
`default_nettype none
module krp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_opcode,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_event_res,
  input  wire logic [3:0]  out_port,
  input  wire logic [2:0]  out_key,
  input  wire logic [31:0] out_resp_time,
  input  wire logic signed [7:0] out_keys_held
);
  import krp_pkg::*;

  // A stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) &&
      $stable(out_port) && $stable(out_key) && $stable(out_resp_time) &&
      $stable(out_keys_held))
    else $error("result beat changed while stalled");

  // Clear beat reports no event and a zero count
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode |=> out_valid &&
      out_event_res == EV_NONE && out_keys_held == 8'sd0)
    else $error("clear beat result wrong");

  // No event means zeroed packet fields
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_NONE |->
      out_port == 4'd0 && out_key == 3'd0 && out_resp_time == 32'd0)
    else $error("fields set without an event");

  // Input beat always yields a result beat next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input beat without result");

endmodule : krp_checker

bind key_response_packet_resync_parser krp_checker u_krp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_opcode     (in_opcode),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_event_res (out_event_res),
  .out_port      (out_port),
  .out_key       (out_key),
  .out_resp_time (out_resp_time),
  .out_keys_held (out_keys_held)
);
`default_nettype wire
